/* hdl/bvcs_pkg.sv */
// Shared types and constants for the best-view camera selector.
// Used by bvcs_core and best_view_camera_select; depends on nothing else.
package bvcs_pkg;

    // Register numbers on the configuration port
    localparam logic [2:0] REG_VIEW_X   = 3'd0;
    localparam logic [2:0] REG_VIEW_Y   = 3'd1;
    localparam logic [2:0] REG_VIEW_Z   = 3'd2;
    localparam logic [2:0] REG_CENTRE_X = 3'd3;
    localparam logic [2:0] REG_CENTRE_Y = 3'd4;
    localparam logic [2:0] REG_CENTRE_Z = 3'd5;
    localparam logic [2:0] REG_TOL      = 3'd6;

    localparam logic [29:0] TOL_RESET = 30'd1074;

    typedef enum logic [3:0] {
        C_IDLE,
        C_LOAD,
        C_SQ,
        C_ZCHK,
        C_NORM,
        C_SQRT,
        C_DIV,
        C_DOT,
        C_DONE
    } core_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        VEC_VIEW,
        VEC_FWD,
        VEC_CTR
    } vec_sel_t;

    typedef struct packed {
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic signed [31:0] view_z;
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [31:0] centre_z;
        logic        [29:0] tol;
    } core_cfg_t;

    typedef struct packed {
        logic               view_ok;
        logic               scored;
        logic signed [31:0] dir_score;
        logic signed [31:0] ctr_score;
    } core_res_t;

endpackage

/* hdl/bvcs_core.sv */
// Scoring engine: normalizes vectors and forms dot products with one shared multiplier,
// an iterative square root and a restoring divider. Depends on bvcs_pkg.
module bvcs_core
    import bvcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               gate,
    input  core_cfg_t          cfg,
    input  logic signed [31:0] fwd_x,
    input  logic signed [31:0] fwd_y,
    input  logic signed [31:0] fwd_z,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               done,
    output core_res_t          res
);

    core_state_t state_reg, state_next;
    vec_sel_t    vsel_reg;
    logic        view_ok_reg, scored_reg, ctr_ok_reg, dsel_reg;

    logic        [31:0] mag_reg [3];
    logic               neg_reg [3];
    logic        [31:0] max_reg;
    logic        [63:0] acc_reg;
    logic        [63:0] prod_reg;
    logic        [4:0]  cnt_reg;
    logic        [1:0]  comp_reg;
    logic        [63:0] sq_x_reg, sq_r_reg, sq_bit_reg;
    logic        [31:0] len_reg, rem_reg;
    logic        [30:0] quo_reg;
    logic signed [31:0] vu_reg [3];
    logic signed [31:0] fu_reg [3];
    logic signed [31:0] tu_reg [3];
    logic signed [31:0] ds_reg, cs_reg;

    // Source vector, magnitudes and pre-scaling
    logic signed [32:0] src [3];
    logic        [32:0] mag33 [3];
    logic        [32:0] max33;
    logic               halve;
    logic        [31:0] mag_ld [3];
    logic        [31:0] max_ld;

    always_comb
    begin
        unique case (vsel_reg)
            VEC_VIEW:
            begin
                src[0] = 33'(cfg.view_x);
                src[1] = 33'(cfg.view_y);
                src[2] = 33'(cfg.view_z);
            end
            VEC_FWD:
            begin
                src[0] = 33'(fwd_x);
                src[1] = 33'(fwd_y);
                src[2] = 33'(fwd_z);
            end
            default:
            begin
                src[0] = 33'(cfg.centre_x) - 33'(pos_x);
                src[1] = 33'(cfg.centre_y) - 33'(pos_y);
                src[2] = 33'(cfg.centre_z) - 33'(pos_z);
            end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            mag33[i] = src[i][32] ? 33'(-src[i]) : 33'(src[i]);
        end
        max33 = mag33[0];
        if (mag33[1] > max33)
            max33 = mag33[1];
        if (mag33[2] > max33)
            max33 = mag33[2];
        halve = max33 > 33'h0_8000_0000;
        for (int i = 0; i < 3; i++)
        begin
            mag_ld[i] = halve ? mag33[i][32:1] : mag33[i][31:0];
        end
        max_ld = halve ? max33[32:1] : max33[31:0];
    end

    // Element selection by component number
    logic        [31:0] mag_sel;
    logic               neg_sel;
    logic signed [31:0] fu_sel, oth_sel;

    always_comb
    begin
        unique case (comp_reg)
            2'd0:
            begin
                mag_sel = mag_reg[0];
                neg_sel = neg_reg[0];
                fu_sel  = fu_reg[0];
                oth_sel = dsel_reg ? tu_reg[0] : vu_reg[0];
            end
            2'd1:
            begin
                mag_sel = mag_reg[1];
                neg_sel = neg_reg[1];
                fu_sel  = fu_reg[1];
                oth_sel = dsel_reg ? tu_reg[1] : vu_reg[1];
            end
            2'd2:
            begin
                mag_sel = mag_reg[2];
                neg_sel = neg_reg[2];
                fu_sel  = fu_reg[2];
                oth_sel = dsel_reg ? tu_reg[2] : vu_reg[2];
            end
            default:
            begin
                mag_sel = '0;
                neg_sel = 1'b0;
                fu_sel  = '0;
                oth_sel = '0;
            end
        endcase
    end

    // Shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == C_SQ)
        begin
            if (comp_reg == 2'd3)
            begin
                mul_a = $signed({3'b000, cfg.tol});
                mul_b = $signed({3'b000, cfg.tol});
            end
            else
            begin
                mul_a = $signed({1'b0, mag_sel});
                mul_b = $signed({1'b0, mag_sel});
            end
        end
        else if (state_reg == C_DOT)
        begin
            mul_a = 33'(fu_sel);
            mul_b = 33'(oth_sel);
        end
    end

    assign mul_p = mul_a * mul_b;

    // Dot product floor and saturation
    logic        [63:0] dot_sum;
    logic signed [63:0] dot_sh;
    logic signed [31:0] dot_score;

    always_comb
    begin
        dot_sum = acc_reg + prod_reg;
        dot_sh  = $signed(dot_sum) >>> 30;
        if (dot_sh > 64'sd2147483647)
            dot_score = 32'sh7fff_ffff;
        else if (dot_sh < -64'sd2147483648)
            dot_score = 32'sh8000_0000;
        else
            dot_score = dot_sh[31:0];
    end

    // Zero-length test against tolerance squared
    logic zero_vec;
    assign zero_vec = acc_reg <= {28'b0, prod_reg[63:28]};

    // Square root step
    logic [63:0] sq_t, sq_x_n, sq_r_n;
    logic        sq_ge;

    always_comb
    begin
        sq_t   = sq_r_reg + sq_bit_reg;
        sq_ge  = sq_x_reg >= sq_t;
        sq_x_n = sq_ge ? sq_x_reg - sq_t : sq_x_reg;
        sq_r_n = sq_ge ? (sq_r_reg >> 1) + sq_bit_reg : sq_r_reg >> 1;
    end

    // Restoring division step
    logic        [32:0] div_t, div_d;
    logic               div_ge;
    logic        [30:0] q_n;
    logic signed [31:0] u_val;

    always_comb
    begin
        div_t  = (cnt_reg == 5'd0) ? {1'b0, mag_sel} : {rem_reg, 1'b0};
        div_d  = div_t - {1'b0, len_reg};
        div_ge = div_t >= {1'b0, len_reg};
        q_n    = {quo_reg[29:0], div_ge};
        u_val  = neg_sel ? -$signed({1'b0, q_n}) : $signed({1'b0, q_n});
    end

    logic div_last;
    assign div_last = (cnt_reg == 5'd30) && (comp_reg == 2'd2);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE: if (start) state_next = C_LOAD;
            C_LOAD: state_next = C_SQ;
            C_SQ:   if (comp_reg == 2'd3) state_next = C_ZCHK;
            C_ZCHK:
            begin
                if (!zero_vec)
                    state_next = C_NORM;
                else if (vsel_reg == VEC_CTR)
                    state_next = C_DOT;
                else
                    state_next = C_DONE;
            end
            C_NORM: if (max_reg[31:30] != 2'b00) state_next = C_SQRT;
            C_SQRT: if (cnt_reg == 5'd31) state_next = C_DIV;
            C_DIV:
            begin
                if (div_last)
                begin
                    unique case (vsel_reg)
                        VEC_VIEW: state_next = gate ? C_LOAD : C_DONE;
                        VEC_FWD:  state_next = C_LOAD;
                        default:  state_next = C_DOT;
                    endcase
                end
            end
            C_DOT:
            begin
                if (comp_reg == 2'd3 && !(dsel_reg == 1'b0 && ctr_ok_reg))
                    state_next = C_DONE;
            end
            C_DONE: state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            vsel_reg    <= VEC_VIEW;
            view_ok_reg <= 1'b0;
            scored_reg  <= 1'b0;
            ctr_ok_reg  <= 1'b0;
            dsel_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        vsel_reg    <= VEC_VIEW;
                        view_ok_reg <= 1'b0;
                        scored_reg  <= 1'b0;
                        ctr_ok_reg  <= 1'b0;
                        dsel_reg    <= 1'b0;
                    end
                end
                C_ZCHK:
                begin
                    if (zero_vec && vsel_reg == VEC_CTR)
                        scored_reg <= 1'b1;
                end
                C_DIV:
                begin
                    if (div_last)
                    begin
                        unique case (vsel_reg)
                            VEC_VIEW:
                            begin
                                view_ok_reg <= 1'b1;
                                vsel_reg    <= VEC_FWD;
                            end
                            VEC_FWD: vsel_reg <= VEC_CTR;
                            default:
                            begin
                                ctr_ok_reg <= 1'b1;
                                scored_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                C_DOT:
                begin
                    if (comp_reg == 2'd3)
                        dsel_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                    cs_reg <= '0;
            end
            C_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= mag_ld[i];
                    neg_reg[i] <= src[i][32];
                end
                max_reg  <= max_ld;
                acc_reg  <= '0;
                comp_reg <= '0;
            end
            C_SQ:
            begin
                prod_reg <= mul_p[63:0];
                if (comp_reg != 2'd0)
                    acc_reg <= acc_reg + prod_reg;
                comp_reg <= comp_reg + 2'd1;
            end
            C_ZCHK:
            begin
                acc_reg  <= zero_vec ? 64'd0 : acc_reg;
                comp_reg <= '0;
            end
            C_NORM:
            begin
                if (max_reg[31:30] == 2'b00)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= {mag_reg[i][30:0], 1'b0};
                    end
                    max_reg <= {max_reg[30:0], 1'b0};
                    acc_reg <= {acc_reg[61:0], 2'b00};
                end
                else
                begin
                    sq_x_reg   <= acc_reg;
                    sq_r_reg   <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                    cnt_reg    <= '0;
                end
            end
            C_SQRT:
            begin
                sq_x_reg   <= sq_x_n;
                sq_r_reg   <= sq_r_n;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (cnt_reg == 5'd31)
                begin
                    len_reg  <= sq_r_n[31:0];
                    cnt_reg  <= '0;
                    comp_reg <= '0;
                end
                else
                    cnt_reg <= cnt_reg + 5'd1;
            end
            C_DIV:
            begin
                rem_reg <= div_ge ? div_d[31:0] : div_t[31:0];
                quo_reg <= q_n;
                if (cnt_reg == 5'd30)
                begin
                    unique case (vsel_reg)
                        VEC_VIEW: vu_reg[comp_reg] <= u_val;
                        VEC_FWD:  fu_reg[comp_reg] <= u_val;
                        default:  tu_reg[comp_reg] <= u_val;
                    endcase
                    cnt_reg  <= '0;
                    comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                    if (comp_reg == 2'd2)
                        acc_reg <= '0;
                end
                else
                    cnt_reg <= cnt_reg + 5'd1;
            end
            C_DOT:
            begin
                prod_reg <= mul_p[63:0];
                if (comp_reg == 2'd3)
                begin
                    acc_reg  <= '0;
                    comp_reg <= '0;
                    if (dsel_reg)
                        cs_reg <= dot_score;
                    else
                        ds_reg <= dot_score;
                end
                else
                begin
                    if (comp_reg != 2'd0)
                        acc_reg <= acc_reg + prod_reg;
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Status toward the top level
    always_comb
    begin
        done          = state_reg == C_DONE;
        res.view_ok   = view_ok_reg;
        res.scored    = scored_reg;
        res.dir_score = ds_reg;
        res.ctr_score = cs_reg;
    end

endmodule

/* hdl/best_view_camera_select.sv */
// Top level of the best-view camera selector: register port, transfer handshakes,
// running-best tracking and the result register. Depends on bvcs_pkg and bvcs_core.
//
//  Channel  Signals                                   Direction  Transfer when
//  config   psel penable pwrite paddr pwdata prdata   in/out     psel & penable & pwrite
//  input    in_valid in_stall + candidate fields      in         in_valid & !in_stall
//  output   out_valid out_stall chosen_index          out        out_valid & !out_stall
//
// A scored candidate keeps in_stall high while each of the three vectors passes through the
// shared unit (up to 30 normalizing shifts, 32 square root steps, 93 divide steps), then
// through two dot products (one if the centre vector is zero) and the done state. A skipped
// candidate passes the view direction only, and a zero view direction ends after the zero
// length test. A run end waits for the result register to be free. Reset clears the registers
// to their defaults and any run in progress.
module best_view_camera_select
    import bvcs_pkg::*;
#(
    parameter int INDEX_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic        [4:0]             paddr,
    input  logic        [31:0]            pwdata,
    output logic        [31:0]            prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          image_available,
    input  logic signed [INDEX_WIDTH-1:0] camera_index,
    input  logic signed [31:0]            forward_x,
    input  logic signed [31:0]            forward_y,
    input  logic signed [31:0]            forward_z,
    input  logic signed [31:0]            position_x,
    input  logic signed [31:0]            position_y,
    input  logic signed [31:0]            position_z,
    input  logic                          last_candidate,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [INDEX_WIDTH-1:0] chosen_index
);

    // Configuration registers
    core_cfg_t cfg_reg;
    logic      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{view_x: '0, view_y: '0, view_z: '0,
                         centre_x: '0, centre_y: '0, centre_z: '0,
                         tol: TOL_RESET};
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_VIEW_X:   cfg_reg.view_x   <= pwdata;
                REG_VIEW_Y:   cfg_reg.view_y   <= pwdata;
                REG_VIEW_Z:   cfg_reg.view_z   <= pwdata;
                REG_CENTRE_X: cfg_reg.centre_x <= pwdata;
                REG_CENTRE_Y: cfg_reg.centre_y <= pwdata;
                REG_CENTRE_Z: cfg_reg.centre_z <= pwdata;
                REG_TOL:      cfg_reg.tol      <= pwdata[29:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[4:2])
            REG_VIEW_X:   prdata = cfg_reg.view_x;
            REG_VIEW_Y:   prdata = cfg_reg.view_y;
            REG_VIEW_Z:   prdata = cfg_reg.view_z;
            REG_CENTRE_X: prdata = cfg_reg.centre_x;
            REG_CENTRE_Y: prdata = cfg_reg.centre_y;
            REG_CENTRE_Z: prdata = cfg_reg.centre_z;
            REG_TOL:      prdata = {2'b00, cfg_reg.tol};
            default:      prdata = '0;
        endcase
    end

    // Sequencer
    top_state_t state_reg, state_next;
    logic       in_xfer, core_start, core_done, out_free;
    core_res_t  core_res;

    logic                          avail_reg, last_reg;
    logic signed [INDEX_WIDTH-1:0] idx_reg;
    logic signed [31:0]            fx_reg, fy_reg, fz_reg, px_reg, py_reg, pz_reg;

    logic                          out_valid_reg;
    logic signed [INDEX_WIDTH-1:0] chosen_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: if (in_valid) state_next = T_RUN;
            T_RUN:  if (core_done) state_next = last_reg ? T_EMIT : T_IDLE;
            T_EMIT: if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall   = state_reg != T_IDLE;
        core_start = state_reg == T_IDLE && in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= T_IDLE;
        else
            state_reg <= state_next;
    end

    // Hold the accepted candidate
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            avail_reg <= image_available;
            idx_reg   <= camera_index;
            fx_reg    <= forward_x;
            fy_reg    <= forward_y;
            fz_reg    <= forward_z;
            px_reg    <= position_x;
            py_reg    <= position_y;
            pz_reg    <= position_z;
            last_reg  <= last_candidate;
        end
    end

    bvcs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (core_start),
        .gate  (avail_reg && !idx_reg[INDEX_WIDTH-1]),
        .cfg   (cfg_reg),
        .fwd_x (fx_reg),
        .fwd_y (fy_reg),
        .fwd_z (fz_reg),
        .pos_x (px_reg),
        .pos_y (py_reg),
        .pos_z (pz_reg),
        .done  (core_done),
        .res   (core_res)
    );

    // Running best and ranking
    logic                          have_best_reg, view_ok_reg;
    logic signed [INDEX_WIDTH-1:0] best_cam_reg;
    logic signed [31:0]            best_ds_reg, best_cs_reg;
    logic signed [33:0]            ds34, cs34, bd34, bc34, tol34;
    logic                          better_d, same_d, better_c, same_c, take;

    always_comb
    begin
        ds34     = 34'(core_res.dir_score);
        cs34     = 34'(core_res.ctr_score);
        bd34     = 34'(best_ds_reg);
        bc34     = 34'(best_cs_reg);
        tol34    = $signed({4'b0000, cfg_reg.tol});
        better_d = !have_best_reg || ds34 > bd34 + tol34;
        same_d   = have_best_reg && (ds34 - bd34 <= tol34) && (bd34 - ds34 <= tol34);
        better_c = cs34 > bc34 + tol34;
        same_c   = (cs34 - bc34 <= tol34) && (bc34 - cs34 <= tol34);
        take     = better_d || (same_d && better_c) ||
                   (same_d && same_c && idx_reg < best_cam_reg);
    end

    // Update the best when a scored candidate ranks higher, emit and clear at a run end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg <= 1'b0;
            best_cam_reg  <= '0;
            best_ds_reg   <= '0;
            best_cs_reg   <= '0;
            view_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == T_RUN && core_done)
            begin
                view_ok_reg <= core_res.view_ok;
                if (core_res.scored && take)
                begin
                    have_best_reg <= 1'b1;
                    best_cam_reg  <= idx_reg;
                    best_ds_reg   <= core_res.dir_score;
                    best_cs_reg   <= core_res.ctr_score;
                end
            end
            if (state_reg == T_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
                have_best_reg <= 1'b0;
                best_cam_reg  <= '0;
                best_ds_reg   <= '0;
                best_cs_reg   <= '0;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == T_EMIT && out_free)
            chosen_reg <= (view_ok_reg && have_best_reg) ? best_cam_reg : '1;
    end

    assign out_valid    = out_valid_reg;
    assign chosen_index = chosen_reg;

`ifndef SYNTH
    // Core finishes only while an item is at work
    assert property (@(posedge clk) disable iff (!rst_n) core_done |-> state_reg == T_RUN)
        else $error("core done outside of a run");

    // A result appears only after a run end
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == T_EMIT))
        else $error("result without run end");

    // The best is cleared once a run has been emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_EMIT && out_free) |=> !have_best_reg)
        else $error("best not cleared at run end");
`endif

endmodule
